@@ src/mps_pkg.sv @@
// match phase sequencer: shared types, phase and command codes, reset values
// and the constants of the seconds-left reciprocal multiply
// no dependencies
`timescale 1ns / 1ps

package mps_pkg;

  localparam int DUR_W   = 24;
  localparam int NOW_W   = 32;
  localparam int LEFT_W  = 15;
  localparam int NUM_W   = 25;
  localparam int MULT_W  = 26;

  // ceil(rem / 1000) = ((rem + 999) * RECIP_MULT) >> RECIP_SHIFT, exact below 2^25
  localparam logic [MULT_W-1:0] RECIP_MULT  = 26'd34359739;
  localparam int                RECIP_SHIFT = 35;
  localparam logic [NUM_W-1:0]  CEIL_BIAS   = 25'd999;

  localparam logic [DUR_W-1:0] AUTO_RST   = 24'd15000;
  localparam logic [DUR_W-1:0] GAP_RST    = 24'd1000;
  localparam logic [DUR_W-1:0] TELEOP_RST = 24'd135000;

  typedef logic [DUR_W-1:0] dur_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_AUTO   = 3'd1,
    PH_GAP    = 3'd2,
    PH_TELEOP = 3'd3,
    PH_ENDED  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_START = 2'd1,
    KIND_STOP  = 2'd2,
    KIND_SKIP  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    MODE_UNKNOWN = 2'd0,
    MODE_AUTO    = 2'd1,
    MODE_TELEOP  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    REG_AUTO   = 2'd0,
    REG_GAP    = 2'd1,
    REG_TELEOP = 2'd2
  } reg_idx_t;

  typedef struct packed {
    dur_t auto_ms;
    dur_t gap_ms;
    dur_t teleop_ms;
  } durs_t;

  // snapshot after the state update, handed to the time-left stages
  typedef struct packed {
    phase_t            phase;
    logic [NOW_W-1:0]  elapsed_ms;
    logic [NOW_W-1:0]  total_ms;
    dur_t              dur_ms;
    logic              elapsed_big;  // elapsed is 2^24 or more
  } snap_t;

  function automatic dur_t dur_of(input phase_t ph, input durs_t d);
    dur_t r;
    unique case (ph)
      PH_AUTO:   r = d.auto_ms;
      PH_GAP:    r = d.gap_ms;
      PH_TELEOP: r = d.teleop_ms;
      default:   r = '0;
    endcase
    return r;
  endfunction

  function automatic phase_t next_phase(input phase_t ph);
    phase_t r;
    unique case (ph)
      PH_AUTO:   r = PH_GAP;
      PH_GAP:    r = PH_TELEOP;
      PH_TELEOP: r = PH_ENDED;
      default:   r = ph;
    endcase
    return r;
  endfunction

endpackage

@@ src/mps_if.sv @@
// match phase sequencer: channel interfaces for input words, result words
// and configuration writes; plain widths, no dependencies
`timescale 1ns / 1ps

interface mps_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] now_ms;

  modport source (output valid, output kind, output now_ms, input ready);
  modport sink (input valid, input kind, input now_ms, output ready);
endinterface

interface mps_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  phase;
  logic        enabled;
  logic [1:0]  mode;
  logic [14:0] time_left_s;
  logic [31:0] phase_elapsed_ms;
  logic [31:0] match_total_ms;
  logic [23:0] phase_remaining_ms;

  modport source (output valid, output phase, output enabled, output mode,
                  output time_left_s, output phase_elapsed_ms, output match_total_ms,
                  output phase_remaining_ms, input ready);
  modport sink (input valid, input phase, input enabled, input mode,
                input time_left_s, input phase_elapsed_ms, input match_total_ms,
                input phase_remaining_ms, output ready);
endinterface

interface mps_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [23:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ src/mps_cfg_regs.sv @@
// match phase sequencer: phase duration registers behind the config port
// depends on mps_pkg and mps_cfg_if
`timescale 1ns / 1ps

module mps_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  mps_cfg_if.sink       cfg_ch,
  output mps_pkg::durs_t durs
);
  import mps_pkg::*;

  durs_t durs_r;

  assign cfg_ch.ready = 1'b1;
  assign durs = durs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      durs_r.auto_ms   <= AUTO_RST;
      durs_r.gap_ms    <= GAP_RST;
      durs_r.teleop_ms <= TELEOP_RST;
    end else if (cfg_ch.valid) begin
      // index beyond the list is dropped
      unique case (reg_idx_t'(cfg_ch.index))
        REG_AUTO:   durs_r.auto_ms   <= cfg_ch.data;
        REG_GAP:    durs_r.gap_ms    <= cfg_ch.data;
        REG_TELEOP: durs_r.teleop_ms <= cfg_ch.data;
        default: ;
      endcase
    end
  end

endmodule

@@ src/mps_phase_ctrl.sv @@
// match phase sequencer: input register, phase state and timing snapshot stage
// depends on mps_pkg and mps_in_if
`timescale 1ns / 1ps

module mps_phase_ctrl #(
  parameter int TIME_BITS = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  mps_in_if.sink          in_ch,
  input  mps_pkg::durs_t  durs,
  input  logic            s1_take,
  output logic            s1_valid,
  output mps_pkg::snap_t  s1_snap
);
  import mps_pkg::*;

  localparam int EXT_W = (TIME_BITS > NOW_W) ? TIME_BITS : NOW_W;

  logic                 s0_v_r;
  kind_t                kind_r;
  logic [TIME_BITS-1:0] now_r;

  phase_t               phase_r, phase_nxt;
  logic [TIME_BITS-1:0] pstart_r, pstart_nxt;
  logic [TIME_BITS-1:0] mstart_r, mstart_nxt;

  logic                 s1_v_r;
  snap_t                snap_r, snap_nxt;

  logic                 s0_adv, s1_adv, s0_fire;
  dur_t                 dur_cur;
  logic [TIME_BITS-1:0] dur_cur_w, ab_sum, e0, tot0, el_new, tot_new;
  logic [EXT_W-1:0]     el_ext, tot_ext;
  logic                 active, expired;

  assign s1_adv   = !s1_v_r || s1_take;
  assign s0_adv   = !s0_v_r || s1_adv;
  assign s0_fire  = s0_v_r && s1_adv;
  assign in_ch.ready = s0_adv;
  assign s1_valid = s1_v_r;
  assign s1_snap  = snap_r;

  assign dur_cur   = dur_of(phase_r, durs);
  assign dur_cur_w = TIME_BITS'(dur_cur);
  assign ab_sum    = TIME_BITS'(durs.auto_ms) + TIME_BITS'(durs.gap_ms);
  assign e0        = now_r - pstart_r;
  assign tot0      = now_r - mstart_r;
  assign active    = (phase_r == PH_AUTO) || (phase_r == PH_GAP) || (phase_r == PH_TELEOP);
  assign expired   = EXT_W'(e0) >= EXT_W'(dur_cur);

  always_comb begin
    phase_nxt  = phase_r;
    pstart_nxt = pstart_r;
    mstart_nxt = mstart_r;
    el_new     = e0;
    tot_new    = tot0;
    unique case (kind_r)
      KIND_START: begin
        phase_nxt  = PH_AUTO;
        pstart_nxt = now_r;
        mstart_nxt = now_r;
        el_new     = '0;
        tot_new    = '0;
      end
      KIND_STOP: begin
        phase_nxt  = PH_IDLE;
        pstart_nxt = '0;
        mstart_nxt = '0;
      end
      KIND_SKIP: begin
        phase_nxt  = PH_TELEOP;
        pstart_nxt = now_r;
        mstart_nxt = now_r - ab_sum;
        el_new     = '0;
        tot_new    = ab_sum;
      end
      KIND_TICK: begin
        // one phase per tick, start moves by the duration so no drift
        if (active && expired) begin
          phase_nxt  = next_phase(phase_r);
          pstart_nxt = pstart_r + dur_cur_w;
          el_new     = e0 - dur_cur_w;
        end
      end
      default: ;
    endcase
    if (phase_nxt == PH_IDLE) begin
      el_new  = '0;
      tot_new = '0;
    end
  end

  assign el_ext  = EXT_W'(el_new);
  assign tot_ext = EXT_W'(tot_new);

  always_comb begin
    snap_nxt.phase       = phase_nxt;
    snap_nxt.elapsed_ms  = el_ext[NOW_W-1:0];
    snap_nxt.total_ms    = tot_ext[NOW_W-1:0];
    snap_nxt.dur_ms      = dur_of(phase_nxt, durs);
    snap_nxt.elapsed_big = (el_ext >> DUR_W) != '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r   <= 1'b0;
      s1_v_r   <= 1'b0;
      phase_r  <= PH_IDLE;
      pstart_r <= '0;
      mstart_r <= '0;
    end else begin
      if (s0_adv) begin
        s0_v_r <= in_ch.valid;
      end
      if (s1_adv) begin
        s1_v_r <= s0_v_r;
      end
      if (s0_fire) begin
        phase_r  <= phase_nxt;
        pstart_r <= pstart_nxt;
        mstart_r <= mstart_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && s0_adv) begin
      kind_r <= kind_t'(in_ch.kind);
      now_r  <= TIME_BITS'(in_ch.now_ms);
    end
    if (s0_fire) begin
      snap_r <= snap_nxt;
    end
  end

endmodule

@@ src/mps_time_left.sv @@
// match phase sequencer: remaining-time stage and result register with the
// seconds-left reciprocal multiply; depends on mps_pkg and mps_out_if
`timescale 1ns / 1ps

module mps_time_left (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            s1_valid,
  input  mps_pkg::snap_t  s1_snap,
  output logic            s1_take,
  mps_out_if.source       out_ch
);
  import mps_pkg::*;

  localparam int PROD_W = NUM_W + MULT_W;

  logic             s2_v_r;
  phase_t           s2_phase_r;
  logic [NOW_W-1:0] s2_el_r, s2_tot_r;
  dur_t             s2_rem_r, rem_nxt;
  logic [NUM_W-1:0] s2_num_r, num_nxt;

  logic              out_v_r;
  phase_t            out_phase_r;
  logic              en_r;
  mode_t             mode_r, mode_nxt;
  logic [LEFT_W-1:0] left_r;
  logic [NOW_W-1:0]  el_r, tot_r;
  dur_t              rem_r;

  logic              out_adv, s2_adv, s1_en;
  logic [PROD_W-1:0] prod;

  assign out_adv = !out_v_r || out_ch.ready;
  assign s2_adv  = !s2_v_r || out_adv;
  assign s1_take = s2_adv;

  assign s1_en   = (s1_snap.phase == PH_AUTO) || (s1_snap.phase == PH_TELEOP);
  assign rem_nxt = (!s1_snap.elapsed_big && (s1_snap.elapsed_ms[DUR_W-1:0] < s1_snap.dur_ms))
                 ? s1_snap.dur_ms - s1_snap.elapsed_ms[DUR_W-1:0] : '0;
  assign num_nxt = s1_en ? NUM_W'(rem_nxt) + CEIL_BIAS : '0;

  assign prod = PROD_W'(s2_num_r) * PROD_W'(RECIP_MULT);

  always_comb begin
    unique case (s2_phase_r)
      PH_AUTO:   mode_nxt = MODE_AUTO;
      PH_TELEOP: mode_nxt = MODE_TELEOP;
      default:   mode_nxt = MODE_UNKNOWN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s2_adv) begin
        s2_v_r <= s1_valid;
      end
      if (out_adv) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s2_adv) begin
      s2_phase_r <= s1_snap.phase;
      s2_el_r    <= s1_snap.elapsed_ms;
      s2_tot_r   <= s1_snap.total_ms;
      s2_rem_r   <= rem_nxt;
      s2_num_r   <= num_nxt;
    end
    if (s2_v_r && out_adv) begin
      out_phase_r <= s2_phase_r;
      en_r        <= (mode_nxt != MODE_UNKNOWN);
      mode_r      <= mode_nxt;
      left_r      <= prod[RECIP_SHIFT +: LEFT_W];
      el_r        <= s2_el_r;
      tot_r       <= s2_tot_r;
      rem_r       <= s2_rem_r;
    end
  end

  assign out_ch.valid              = out_v_r;
  assign out_ch.phase              = out_phase_r;
  assign out_ch.enabled            = en_r;
  assign out_ch.mode               = mode_r;
  assign out_ch.time_left_s        = left_r;
  assign out_ch.phase_elapsed_ms   = el_r;
  assign out_ch.match_total_ms     = tot_r;
  assign out_ch.phase_remaining_ms = rem_r;

endmodule

@@ src/match_phase_sequencer_core.sv @@
// channel  | dir | payload                                            | handshake
// in_ch    | in  | kind[1:0], now_ms[31:0]                            | valid/ready
// out_ch   | out | phase, enabled, mode, time_left_s, phase_elapsed_ms, | valid/ready
//          |     | match_total_ms, phase_remaining_ms                 |
// cfg_ch   | in  | index[1:0], data[23:0]                             | valid/ready (always ready)
//
// one word per cycle sustained while out_ch takes results; a result passes through
// the input register, phase state update, remaining time and reciprocal multiply
// the phase state register updates once per word, which sets the rate
// rst_n clears the phase to idle, both start times to zero, durations to defaults
// out_ch stalls hold the output and every full stage behind it; in_ch.ready drops only once all four stages are full
// top level of the match phase sequencer; depends on mps_pkg, mps_if and submodules
`timescale 1ns / 1ps

module match_phase_sequencer_core #(
  parameter int TIME_BITS = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  mps_in_if.sink   in_ch,
  mps_out_if.source out_ch,
  mps_cfg_if.sink  cfg_ch
);
  import mps_pkg::*;

  durs_t durs;
  logic  s1_valid, s1_take;
  snap_t s1_snap;

  mps_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .durs   (durs)
  );

  mps_phase_ctrl #(
    .TIME_BITS (TIME_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .durs     (durs),
    .s1_take  (s1_take),
    .s1_valid (s1_valid),
    .s1_snap  (s1_snap)
  );

  mps_time_left u_left (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s1_snap  (s1_snap),
    .s1_take  (s1_take),
    .out_ch   (out_ch)
  );

`ifndef SYNTH
  // seconds left only in auto or teleop
  a_left_zero_disabled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.enabled) |-> (out_ch.time_left_s == '0))
    else $error("time left nonzero outside auto and teleop");

  // idle word carries an all-zero snapshot
  a_idle_snapshot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.phase == PH_IDLE)) |->
      (out_ch.phase_elapsed_ms == '0 && out_ch.match_total_ms == '0 &&
       out_ch.phase_remaining_ms == '0))
    else $error("idle word with nonzero snapshot");

  // reciprocal multiply gives the rounded-up seconds
  a_left_ceil: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.enabled) |->
      ((32'(out_ch.time_left_s) * 32'd1000 >= 32'(out_ch.phase_remaining_ms)) &&
       (32'(out_ch.time_left_s) * 32'd1000 < 32'(out_ch.phase_remaining_ms) + 32'd1000)))
    else $error("seconds left not the ceiling of remaining ms");

  // input stalls only when every stage holds a word and the output is stalled
  a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (out_ch.valid && !out_ch.ready))
    else $error("input stalled with room in the pipeline");
`endif

endmodule

@@ dv/match_phase_sequencer_core_test.sv @@
// testbench for match_phase_sequencer_core: directed and random command words
// are checked against an in-bench phase timer model, with random idling
// depends on mps_pkg, mps_if and the sequencer rtl
`timescale 1ns / 1ps

module match_phase_sequencer_core_test;
  import mps_pkg::*;

  localparam int LATENCY     = 4;
  localparam int LIMIT       = 400000;
  localparam int HOLD_AT     = 200;
  localparam int HOLD_CYCLES = 150;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] now_ms;
  } cmd_word_t;

  typedef struct packed {
    phase_t      phase;
    logic        enabled;
    mode_t       mode;
    logic [14:0] time_left_s;
    logic [31:0] elapsed_ms;
    logic [31:0] total_ms;
    dur_t        remaining_ms;
  } snapshot_t;

  logic clk;
  logic rst_n;
  logic calm = 1'b0;

  mps_in_if  in_bus();
  mps_out_if out_bus();
  mps_cfg_if cfg_bus();

  match_phase_sequencer_core #(.TIME_BITS(32)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  // timer model state
  dur_t        len_auto, len_gap, len_teleop;
  phase_t      cur_phase;
  logic [31:0] phase_t0, match_t0;

  cmd_word_t pending_words[$];
  snapshot_t expected_snaps[$];

  int n_errors  = 0;
  int n_sent    = 0;
  int send_gap  = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int cycle_cnt = 0;

  function automatic dur_t phase_len(input phase_t ph);
    case (ph)
      PH_AUTO:   return len_auto;
      PH_GAP:    return len_gap;
      PH_TELEOP: return len_teleop;
      default:   return '0;
    endcase
  endfunction

  task automatic sequencer_step(input kind_t k, input logic [31:0] now, output snapshot_t s);
    dur_t        dur;
    logic [31:0] el;
    logic [31:0] secs;
    case (k)
      KIND_START: begin
        match_t0  = now;
        phase_t0  = now;
        cur_phase = PH_AUTO;
      end
      KIND_STOP: begin
        cur_phase = PH_IDLE;
        match_t0  = '0;
        phase_t0  = '0;
      end
      KIND_SKIP: begin
        match_t0  = now - {8'd0, len_auto} - {8'd0, len_gap};
        phase_t0  = now;
        cur_phase = PH_TELEOP;
      end
      default: begin
        if (cur_phase == PH_AUTO || cur_phase == PH_GAP || cur_phase == PH_TELEOP) begin
          dur = phase_len(cur_phase);
          el  = now - phase_t0;
          // one phase per tick, start moves by the duration to avoid drift
          if (el >= {8'd0, dur}) begin
            phase_t0 = phase_t0 + {8'd0, dur};
            case (cur_phase)
              PH_AUTO: cur_phase = PH_GAP;
              PH_GAP:  cur_phase = PH_TELEOP;
              default: cur_phase = PH_ENDED;
            endcase
          end
        end
      end
    endcase

    s.phase   = cur_phase;
    s.enabled = (cur_phase == PH_AUTO || cur_phase == PH_TELEOP);
    s.mode    = cur_phase == PH_AUTO ? MODE_AUTO :
                (cur_phase == PH_TELEOP ? MODE_TELEOP : MODE_UNKNOWN);
    if (cur_phase == PH_IDLE) begin
      s.elapsed_ms   = '0;
      s.total_ms     = '0;
      s.remaining_ms = '0;
    end else begin
      dur            = phase_len(cur_phase);
      s.elapsed_ms   = now - phase_t0;
      s.total_ms     = now - match_t0;
      s.remaining_ms = s.elapsed_ms < {8'd0, dur} ? dur - s.elapsed_ms[23:0] : '0;
    end
    secs          = ({8'd0, s.remaining_ms} + 32'd999) / 32'd1000;
    s.time_left_s = s.enabled ? secs[14:0] : '0;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t mismatch %s: expected %0d, actual %0d", $time, name, want, got);
      n_errors++;
    end
  endtask

  task automatic push_word(input kind_t k, input logic [31:0] t);
    cmd_word_t w;
    w.kind   = k;
    w.now_ms = t;
    pending_words.push_back(w);
  endtask

  task automatic write_reg(input reg_idx_t idx, input dur_t val);
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    case (idx)
      REG_AUTO: len_auto   = val;
      REG_GAP:  len_gap    = val;
      default:  len_teleop = val;
    endcase
  endtask

  task automatic set_lengths(input dur_t a, input dur_t g, input dur_t t);
    write_reg(REG_AUTO, a);
    write_reg(REG_GAP, g);
    write_reg(REG_TELEOP, t);
  endtask

  // wait until every word went in and every result came back
  task automatic drain();
    while (pending_words.size() != 0 || in_bus.valid || expected_snaps.size() != 0)
      @(negedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // a well-formed match: start, then mostly ticks with rising timestamps
  task automatic play_match(input int n_words);
    logic [31:0] t;
    int          span;
    int          r;
    kind_t       k;
    t    = $urandom;
    span = (int'(len_auto) + int'(len_gap) + int'(len_teleop)) / 24 + 2;
    push_word(KIND_START, t);
    for (int i = 1; i < n_words; i++) begin
      r = $urandom_range(0, 99);
      if (r < 82) t = t + $urandom_range(0, span);
      else if (r < 87) t = t - $urandom_range(0, 50);
      else if (r < 95) t = t + $urandom_range(0, span * 30);
      else t = $urandom;
      r = $urandom_range(0, 99);
      if (r < 90) k = KIND_TICK;
      else if (r < 95) k = KIND_SKIP;
      else if (r < 98) k = KIND_START;
      else k = KIND_STOP;
      push_word(k, t);
    end
  endtask

  task automatic random_phase(input int n_words);
    int cnt;
    int len;
    cnt = 0;
    while (cnt < n_words) begin
      if ($urandom_range(0, 9) < 8) begin
        len = $urandom_range(20, 90);
        play_match(len);
        cnt += len;
      end else begin
        push_word(kind_t'($urandom_range(0, 3)), $urandom);
        cnt++;
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // driver: one word in flight on in_bus, idles in short bursts
  always @(posedge clk) begin : drv
    cmd_word_t w;
    snapshot_t s;
    logic      take;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      send_gap     <= 0;
      n_sent       <= 0;
    end else begin
      take = in_bus.valid && in_bus.ready;
      if (take) begin
        sequencer_step(kind_t'(in_bus.kind), in_bus.now_ms, s);
        expected_snaps.push_back(s);
        n_sent <= n_sent + 1;
      end
      if (take || !in_bus.valid) begin
        if (send_gap != 0) begin
          send_gap     <= send_gap - 1;
          in_bus.valid <= 1'b0;
        end else if (!calm && hold_left == 0 && pending_words.size() != 0 &&
                     $urandom_range(0, 9) == 0) begin
          send_gap     <= $urandom_range(0, 3);
          in_bus.valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          w             = pending_words.pop_front();
          in_bus.valid  <= 1'b1;
          in_bus.kind   <= w.kind;
          in_bus.now_ms <= w.now_ms;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // one long receiver hold-off so the pipe fills and in_bus stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (n_sent == HOLD_AT && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor: compare each result word with the oldest expectation
  always @(posedge clk) begin : mon
    snapshot_t want;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      stall_left    <= 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_snaps.size() == 0) begin
          $display("%0t unexpected result word: phase %0d", $time, out_bus.phase);
          n_errors++;
        end else begin
          want = expected_snaps.pop_front();
          check_field("phase", 32'(want.phase), 32'(out_bus.phase));
          check_field("enabled", 32'(want.enabled), 32'(out_bus.enabled));
          check_field("mode", 32'(want.mode), 32'(out_bus.mode));
          check_field("time_left_s", 32'(want.time_left_s), 32'(out_bus.time_left_s));
          check_field("phase_elapsed_ms", want.elapsed_ms, out_bus.phase_elapsed_ms);
          check_field("match_total_ms", want.total_ms, out_bus.match_total_ms);
          check_field("phase_remaining_ms", 32'(want.remaining_ms),
                      32'(out_bus.phase_remaining_ms));
        end
      end
      if (hold_left != 0) begin
        out_bus.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left    <= stall_left - 1;
        out_bus.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left    <= $urandom_range(0, 3);
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    logic [31:0] s0;
    rst_n          = 1'b0;
    in_bus.valid   = 1'b0;
    in_bus.kind    = KIND_TICK;
    in_bus.now_ms  = '0;
    out_bus.ready  = 1'b0;
    cfg_bus.valid  = 1'b0;
    cfg_bus.index  = REG_AUTO;
    cfg_bus.data   = '0;
    len_auto       = AUTO_RST;
    len_gap        = GAP_RST;
    len_teleop     = TELEOP_RST;
    cur_phase      = PH_IDLE;
    phase_t0       = '0;
    match_t0       = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset lengths: idle ticks, rounding edges, late and wrapped ticks
    s0 = 32'hFFFF_FF00;
    push_word(KIND_TICK, 32'h0);
    push_word(KIND_STOP, 32'hFFFF_FFFF);
    push_word(KIND_START, s0);
    push_word(KIND_TICK, s0 + 32'h200);
    push_word(KIND_TICK, s0 + 32'd14000);
    push_word(KIND_TICK, s0 + 32'd13999);
    push_word(KIND_TICK, s0 + 32'd15000);
    push_word(KIND_TICK, s0 + 32'd215000);
    push_word(KIND_TICK, s0 + 32'd215000);
    push_word(KIND_TICK, s0 + 32'd300000);
    push_word(KIND_STOP, 32'h5555_5555);
    push_word(KIND_START, 32'h0);
    push_word(KIND_TICK, 32'hFFFF_FFFF);
    push_word(KIND_TICK, 32'h5);
    push_word(KIND_SKIP, 32'd500);
    push_word(KIND_TICK, 32'd134501);
    push_word(KIND_START, 32'd1000);
    push_word(KIND_SKIP, 32'd1001);
    push_word(KIND_STOP, 32'd2000);
    push_word(KIND_SKIP, 32'h8000_0000);
    push_word(KIND_TICK, 32'h8000_0000 + 32'd135000);
    push_word(KIND_STOP, 32'hAAAA_AAAA);
    drain();

    // zero lengths advance on every tick
    set_lengths(24'd0, 24'd0, 24'd0);
    push_word(KIND_START, 32'd7);
    push_word(KIND_TICK, 32'd7);
    push_word(KIND_TICK, 32'd7);
    push_word(KIND_TICK, 32'd7);
    push_word(KIND_SKIP, 32'd9);
    drain();

    // full-scale lengths
    set_lengths(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
    push_word(KIND_START, 32'd0);
    push_word(KIND_TICK, 32'd1);
    push_word(KIND_TICK, 32'h00FF_FFFF);
    push_word(KIND_SKIP, 32'd10);
    drain();

    set_lengths(AUTO_RST, GAP_RST, TELEOP_RST);
    random_phase(330);
    drain();

    set_lengths(dur_t'($urandom_range(0, 40)), dur_t'($urandom_range(0, 40)),
                dur_t'($urandom_range(0, 40)));
    random_phase(330);
    drain();

    set_lengths(dur_t'($urandom), dur_t'($urandom), dur_t'($urandom));
    random_phase(330);
    drain();

    set_lengths(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
    random_phase(300);
    drain();

    // last stretch runs with both sides always active
    set_lengths(24'd0, dur_t'($urandom_range(1, 3000)), 24'd0);
    calm <= 1'b1;
    random_phase(300);
    drain();

    if (expected_snaps.size() != 0) begin
      $display("%0t %0d result words never arrived", $time, expected_snaps.size());
      n_errors++;
    end
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
